FILE: rtl/scan_azimuth_segmenter_unit_macros.svh
// Assertion macros shared by the scan azimuth segmenter RTL.
// Depends on nothing; included by the top level only.
`ifndef SCAN_AZIMUTH_SEGMENTER_UNIT_MACROS_SVH
`define SCAN_AZIMUTH_SEGMENTER_UNIT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define SAS_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("sas implication violated");

// Condition c never holds.
`define SAS_ASSERT_NEVER(label, clk, rst, c) \
   label: assert property (@(posedge clk) disable iff (rst) !(c)) \
      else $error("sas forbidden condition seen");

`endif

FILE: rtl/sas_pkg.sv
// Package of the scan azimuth segmenter: result type and CORDIC arctangent table.
// Depends on nothing; used by all modules but the step divider, by scoped names.
package sas_pkg;

   // One result item as it leaves the back end.
   typedef struct packed {
      logic       keep;
      logic       segment_closed_before;
      logic [8:0] segment_number;
      logic [17:0] azimuth;
      logic       sweep_done;
   } sas_result_type;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 4;

   // atan(2^-i) in units of 2^-32 turn, rounded.
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'h20000000;
         1: v = 32'h12E4051E;
         2: v = 32'h09FB385B;
         3: v = 32'h051111D4;
         4: v = 32'h028B0D43;
         5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;
         7: v = 32'h00517C55;
         8: v = 32'h0028BE53;
         9: v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/sas_step_div.sv
// Bit-serial divider that forms the segment step, one turn over the pose count.
// Depends on nothing outside this file.
module sas_step_div #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [7:0]            pose_count,
   output logic                  busy,
   output logic [ANGLE_BITS:0]   step
);
   localparam int IW = $clog2(ANGLE_BITS + 1);
   localparam logic [ANGLE_BITS:0] RESET_STEP = (ANGLE_BITS + 1)'((64'd1 << ANGLE_BITS) / 20);

   logic                busy_ff, busy_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [7:0]          div_ff, div_in;
   logic [7:0]          rem_ff, rem_in;
   logic [ANGLE_BITS:0] quo_ff, quo_in;
   logic [ANGLE_BITS:0] step_ff, step_in;
   logic [8:0]          trial;
   logic                ge;

   // One quotient bit per cycle, dividend bits taken from the top down.
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      trial   = {rem_ff, (32'(idx_ff) == ANGLE_BITS)};
      ge      = trial >= {1'b0, div_ff};
      if (load) begin
         busy_in = 1'b1;
         idx_in  = IW'(ANGLE_BITS);
         div_in  = (pose_count == 8'd0) ? 8'd1 : pose_count;
         rem_in  = 8'd0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? 8'(trial - {1'b0, div_ff}) : trial[7:0];
         quo_in = {quo_ff[ANGLE_BITS-1:0], ge};
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            step_in = {quo_ff[ANGLE_BITS-1:0], ge};
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= RESET_STEP;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      idx_ff <= idx_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign step = step_ff;
endmodule

FILE: rtl/sas_cordic_front.sv
// Front end: pipelined CORDIC vectoring that turns a point into a clockwise azimuth.
// Depends on sas_pkg for the arctangent table.
module sas_cordic_front #(
   parameter int COORD_BITS    = 24,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic                         in_start,
   output logic                         out_valid,
   output logic [ANGLE_BITS:0]          out_ori,
   output logic                         out_start
);
   localparam int W     = 43;
   localparam int ZW    = 34;
   localparam int SCALE = 40 - COORD_BITS;
   localparam int N     = CORDIC_STAGES;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1 << 30);
   localparam logic signed [ZW-1:0] HALF_LSB = ZW'(64'd1 << (31 - ANGLE_BITS));
   localparam logic signed [ZW-1:0] TURN_Z = ZW'(64'd1 << ANGLE_BITS);

   logic signed [W-1:0]  x_ff [0:N];
   logic signed [W-1:0]  y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic                 v_ff [0:N];
   logic                 s_ff [0:N];
   logic                 o_ff [0:N];
   logic                 vout_ff;
   logic [ANGLE_BITS:0]  ori_ff;
   logic                 sout_ff;

   logic signed [W-1:0]  xs, ys, x0, y0;
   logic signed [ZW-1:0] z0, zr, az, ori_w;

   // Scale the coordinates and fold the left half plane by a quarter turn.
   always_comb begin
      xs = W'(in_x) <<< SCALE;
      ys = W'(in_y) <<< SCALE;
      x0 = xs;
      y0 = ys;
      z0 = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0 = ys;
            y0 = -xs;
            z0 = QUARTER;
         end else begin
            x0 = -ys;
            y0 = xs;
            z0 = -QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
      if (advance) begin
         x_ff[0] <= x0;
         y_ff[0] <= y0;
         z_ff[0] <= z0;
         s_ff[0] <= in_start;
         o_ff[0] <= (in_x == '0) && (in_y == '0);
      end
   end

   // One vectoring rotation per stage; a stage with y at zero passes through.
   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic signed [W-1:0]  dx, dy, xn, yn;
      logic signed [ZW-1:0] zn, at;
      always_comb begin
         dx = x_ff[k-1] >>> (k - 1);
         dy = y_ff[k-1] >>> (k - 1);
         at = ZW'(sas_pkg::atan_turns(k - 1));
         xn = x_ff[k-1];
         yn = y_ff[k-1];
         zn = z_ff[k-1];
         if (y_ff[k-1] > 0) begin
            xn = x_ff[k-1] + dy;
            yn = y_ff[k-1] - dx;
            zn = z_ff[k-1] + at;
         end else if (y_ff[k-1] < 0) begin
            xn = x_ff[k-1] - dy;
            yn = y_ff[k-1] + dx;
            zn = z_ff[k-1] - at;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (advance) begin
            x_ff[k] <= xn;
            y_ff[k] <= yn;
            z_ff[k] <= zn;
            s_ff[k] <= s_ff[k-1];
            o_ff[k] <= o_ff[k-1];
         end
      end
   end

   // Round to angle units and mirror to the clockwise sense.
   always_comb begin
      zr    = z_ff[N] + HALF_LSB;
      az    = zr >>> (32 - ANGLE_BITS);
      ori_w = (az < 0) ? -az : TURN_Z - az;
      if (o_ff[N]) begin
         ori_w = TURN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (advance) begin
         vout_ff <= v_ff[N];
      end
      if (advance) begin
         ori_ff  <= ori_w[ANGLE_BITS:0];
         sout_ff <= s_ff[N];
      end
   end

   assign out_valid = vout_ff;
   assign out_ori   = ori_ff;
   assign out_start = sout_ff;
endmodule

FILE: rtl/sas_queue.sv
// Short queue between the CORDIC front end and the segmenting back end.
// Depends on sas_pkg for its depth.
module sas_queue #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int D  = sas_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);

   logic [WIDTH-1:0] mem_ff [0:D-1];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;

   // Circular buffer with an occupancy count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PW + 1)'(push) - (PW + 1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ff];
   assign full     = (cnt_ff == (PW + 1)'(D));
   assign empty    = (cnt_ff == '0);
endmodule

FILE: rtl/sas_back.sv
// Back end: azimuth unwrapping, segment thresholds and sweep stop, with result register.
// Depends on sas_pkg for the result type.
module sas_back #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [ANGLE_BITS:0]    in_ori,
   input  logic                   in_start,
   input  logic [ANGLE_BITS:0]    cfg_step,
   output logic                   in_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sas_pkg::sas_result_type out_result
);
   localparam int AW = ANGLE_BITS + 1;
   localparam int UW = ANGLE_BITS + 3;
   localparam logic [UW-1:0] TURN = UW'(64'd1 << ANGLE_BITS);
   localparam logic [UW-1:0] TOL  = UW'(((64'd1 << ANGLE_BITS) + 64'd900) / 64'd1800);
   localparam logic [AW-1:0] RESET_STEP = AW'((64'd1 << ANGLE_BITS) / 20);

   logic [AW-1:0] start_ff, start_in, start_e;
   logic          wrap_ff, wrap_in, wrap_e;
   logic [8:0]    seg_ff, seg_in, seg_e;
   logic [UW-1:0] thr_ff, thr_in, thr_e;
   logic [AW-1:0] step_ff, step_in, step_e;
   logic          stop_ff, stop_in, stop_e;
   logic [UW-1:0] un;
   logic          closed, keep;
   logic          rv_ff;
   sas_pkg::sas_result_type res_ff, res_in;

   assign in_pop = in_valid && (!rv_ff || out_ready);

   // Per-point state update; a sweep start replaces the held state first.
   always_comb begin
      start_e = in_start ? in_ori : start_ff;
      wrap_e  = in_start ? 1'b0 : wrap_ff;
      seg_e   = in_start ? 9'd1 : seg_ff;
      step_e  = in_start ? cfg_step : step_ff;
      thr_e   = in_start ? UW'(in_ori) + UW'(cfg_step) : thr_ff;
      stop_e  = in_start ? 1'b0 : stop_ff;
      start_in = start_e;
      step_in  = step_e;
      wrap_in  = wrap_e;
      seg_in   = seg_e;
      thr_in   = thr_e;
      stop_in  = stop_e;
      closed   = 1'b0;
      keep     = 1'b0;
      if (!stop_e && (UW'(in_ori) + TOL < UW'(start_e))) begin
         wrap_in = 1'b1;
      end
      un = UW'(in_ori) + (wrap_in ? TURN : '0);
      if (!stop_e) begin
         if (un >= thr_e) begin
            closed = 1'b1;
            seg_in = seg_e + 9'd1;
            thr_in = thr_e + UW'(step_e);
         end
         if (un >= UW'(start_e) + TURN) begin
            stop_in = 1'b1;
         end else begin
            keep = 1'b1;
         end
      end
      res_in.keep                  = keep;
      res_in.segment_closed_before = closed;
      res_in.segment_number        = seg_in;
      res_in.azimuth               = 18'(un);
      res_in.sweep_done            = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         wrap_ff  <= 1'b0;
         seg_ff   <= 9'd1;
         thr_ff   <= '0;
         step_ff  <= RESET_STEP;
         stop_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (in_pop) begin
            start_ff <= start_in;
            wrap_ff  <= wrap_in;
            seg_ff   <= seg_in;
            thr_ff   <= thr_in;
            step_ff  <= step_in;
            stop_ff  <= stop_in;
            rv_ff    <= 1'b1;
         end else if (out_ready) begin
            rv_ff <= 1'b0;
         end
      end
      if (in_pop) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = rv_ff;
   assign out_result = res_ff;
endmodule

FILE: rtl/scan_azimuth_segmenter_unit.sv
// Points pass through the pipelined CORDIC front, the queue and the result register, with
// throughput one point per cycle when unstalled. A pose count write starts a bit-serial
// divide, during which no point or further write is taken. Synchronous active-high reset
// empties the pipeline and queue and restores pose count 20 with its step; no clearing
// pass is needed.
module scan_azimuth_segmenter_unit #(
   parameter int ANGLE_BITS    = 16,
   parameter int COORD_BITS    = 24,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic                         req_sweep_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_keep,
   output logic                         rsp_segment_closed_before,
   output logic [8:0]                   rsp_segment_number,
   output logic [17:0]                  rsp_azimuth,
   output logic                         rsp_sweep_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [7:0]                   csr_data
);
   `include "scan_azimuth_segmenter_unit_macros.svh"

   localparam int AW = ANGLE_BITS + 1;

   logic          div_busy;
   logic [AW-1:0] cfg_step;
   logic          advance;
   logic          f_valid, f_start;
   logic [AW-1:0] f_ori;
   logic          q_push, q_pop, q_full, q_empty;
   logic [AW:0]   q_out;
   sas_pkg::sas_result_type result;

   // Step divider, restarted by each pose count transfer.
   sas_step_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
      .clock(clock), .reset(reset), .load(csr_valid && csr_ready),
      .pose_count(csr_data), .busy(div_busy), .step(cfg_step)
   );
   assign csr_ready = !div_busy;

   // The front pipeline holds only while its last stage cannot enter the queue.
   assign advance   = !(f_valid && q_full);
   assign req_ready = advance && !div_busy;

   sas_cordic_front #(
      .COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)
   ) u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid && req_ready), .in_x(req_coord_x), .in_y(req_coord_y),
      .in_start(req_sweep_start), .out_valid(f_valid), .out_ori(f_ori),
      .out_start(f_start)
   );

   assign q_push = f_valid && !q_full;

   sas_queue #(.WIDTH(AW + 1)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data({f_start, f_ori}),
      .pop(q_pop), .pop_data(q_out), .full(q_full), .empty(q_empty)
   );

   sas_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_ori(q_out[AW-1:0]),
      .in_start(q_out[AW]), .cfg_step(cfg_step), .in_pop(q_pop),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_result(result)
   );

   assign rsp_keep                  = result.keep;
   assign rsp_segment_closed_before = result.segment_closed_before;
   assign rsp_segment_number        = result.segment_number;
   assign rsp_azimuth               = result.azimuth;
   assign rsp_sweep_done            = result.sweep_done;

   // A dropped point always belongs to a stopped sweep.
   `SAS_ASSERT_IMPLY(a_drop_means_done, clock, reset, rsp_valid && !rsp_keep, rsp_sweep_done)
   // No point enters while the step divide is running.
   `SAS_ASSERT_NEVER(a_no_point_in_divide, clock, reset, req_ready && !csr_ready)
   // The queue is never pushed while full.
   `SAS_ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_full)
endmodule

FILE: test/scan_azimuth_segmenter_unit_tb.sv
// Self-checking testbench for the scan azimuth segmenter: drives lidar points, predicts
// clockwise azimuth, unwrap and pose-segment results, and compares every result transfer.
// Depends on sas_pkg and scan_azimuth_segmenter_unit in the rtl folder.
module scan_azimuth_segmenter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ABITS = 16;
   localparam int CBITS = 24;
   localparam int NSTAGE = 16;
   localparam longint TURN = 64'sd1 << ABITS;
   localparam longint TOL = (TURN + 900) / 1800;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CBITS-1:0] req_coord_x = '0;
   logic signed [CBITS-1:0] req_coord_y = '0;
   logic req_sweep_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_keep, rsp_segment_closed_before, rsp_sweep_done;
   logic [8:0] rsp_segment_number;
   logic [17:0] rsp_azimuth;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   scan_azimuth_segmenter_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_sweep_start(req_sweep_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_keep(rsp_keep), .rsp_segment_closed_before(rsp_segment_closed_before),
      .rsp_segment_number(rsp_segment_number), .rsp_azimuth(rsp_azimuth),
      .rsp_sweep_done(rsp_sweep_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Predictor state, a private copy of the block's sweep state.
   logic [7:0] pose_count_q;
   longint start_az, seg_step, next_edge;
   logic   unwrapped_flag, halted;
   logic [8:0] seg_count;

   sas_pkg::sas_result_type expected_results[$];
   int  failures = 0;
   bit  quiet_tail = 0;
   bit  long_hold = 0;
   int  idle_cycles = 0;

   // Append one predicted result at the tail of the expectation queue.
   function automatic void queue_expected(sas_pkg::sas_result_type r);
      expected_results = {expected_results, r};
   endfunction

   // Floor division by a power of two.
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // Clockwise azimuth in 1..TURN from a fixed-length CORDIC vectoring run.
   function automatic longint cw_azimuth(longint x, longint y);
      longint z, t, dx, dy, a;
      logic [31:0] step_angle;
      z = 0;
      if (x == 0 && y == 0) return TURN;
      x = x * (64'sd1 << (40 - CBITS));
      y = y * (64'sd1 << (40 - CBITS));
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 64'sd1 << 30;
         end else begin
            x = -y; y = t; z = -(64'sd1 << 30);
         end
      end
      for (int i = 0; i < NSTAGE; i++) begin
         dx = shr_floor(x, i);
         dy = shr_floor(y, i);
         step_angle = sas_pkg::atan_turns(i);
         if (y > 0) begin
            x += dy; y -= dx; z += longint'(step_angle);
         end else if (y < 0) begin
            x -= dy; y += dx; z -= longint'(step_angle);
         end
      end
      a = shr_floor(z + (64'sd1 << (31 - ABITS)), 32 - ABITS);
      return (a < 0) ? -a : TURN - a;
   endfunction

   function automatic void reset_sweep_state();
      pose_count_q = 8'd20;
      start_az = 0; unwrapped_flag = 0; seg_count = 9'd1;
      next_edge = 0; seg_step = TURN / 20; halted = 0;
   endfunction

   // Advance the sweep state by one point and return its result.
   function automatic sas_pkg::sas_result_type segment_point(logic signed [CBITS-1:0] cx,
                                                            logic signed [CBITS-1:0] cy,
                                                            logic first);
      sas_pkg::sas_result_type r;
      longint az, un;
      az = cw_azimuth(longint'(cx), longint'(cy));
      r = '0;
      if (first) begin
         start_az = az; unwrapped_flag = 0; seg_count = 9'd1;
         seg_step = TURN / ((pose_count_q == 0) ? 1 : pose_count_q);
         next_edge = start_az + seg_step; halted = 0;
      end
      if (halted) begin
         un = az + (unwrapped_flag ? TURN : 0);
      end else begin
         if (az + TOL < start_az) unwrapped_flag = 1;
         un = az + (unwrapped_flag ? TURN : 0);
         if (un >= next_edge) begin
            r.segment_closed_before = 1;
            seg_count = seg_count + 9'd1;
            next_edge += seg_step;
         end
         if (un >= start_az + TURN) halted = 1;
         else r.keep = 1;
      end
      r.segment_number = seg_count;
      r.azimuth = un[17:0];
      r.sweep_done = halted;
      return r;
   endfunction

   // Directed stimulus: x, y, sweep start, and a typed expectation where obvious.
   typedef struct {
      logic signed [CBITS-1:0] x, y;
      logic first;
      bit   fixed;
      sas_pkg::sas_result_type res;
   } point_row_type;

   point_row_type directed_rows[$];

   function automatic point_row_type row(int x, int y, logic f);
      point_row_type p;
      p.x = CBITS'(x); p.y = CBITS'(y); p.first = f; p.fixed = 0; p.res = '0;
      return p;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(point_row_type p);
      directed_rows = {directed_rows, p};
   endfunction

   // Sender: drive one point and hold it until the transfer; valid stays up afterwards
   // so that the next point can follow at once.
   task automatic send_point(logic signed [CBITS-1:0] x, logic signed [CBITS-1:0] y,
                             logic f);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x; req_coord_y <= y; req_sweep_start <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_expected(segment_point(x, y, f));
   endtask

   task automatic write_pose_count(logic [7:0] v);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1; csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      pose_count_q = v;
   endtask

   // Random point, mostly on an ordered clockwise walk, with full-scale noise.
   task automatic send_sweep(int n);
      longint ang;
      int r;
      real th;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_point(CBITS'($urandom), CBITS'($urandom), ($urandom_range(0, 30) == 0));
         end else begin
            ang = -(i * 360 / n) - int'($urandom_range(0, 20));
            th = ang * 3.14159265 / 180.0;
            r = $urandom_range(1, 8000000);
            send_point(CBITS'(int'(r * $cos(th))), CBITS'(int'(r * $sin(th))), i == 0);
         end
      end
   endtask

   // Receiver with random stalls, one long hold-off and a quiet tail.
   initial begin
      int s;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
            long_hold = 0;
         end
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (s) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      sas_pkg::sas_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            failures++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_keep !== e.keep) begin
               $error("keep: expected %0d actual %0d", e.keep, rsp_keep); failures++;
            end
            if (rsp_segment_closed_before !== e.segment_closed_before) begin
               $error("segment_closed_before: expected %0d actual %0d",
                      e.segment_closed_before, rsp_segment_closed_before); failures++;
            end
            if (rsp_segment_number !== e.segment_number) begin
               $error("segment_number: expected %0d actual %0d",
                      e.segment_number, rsp_segment_number); failures++;
            end
            if (rsp_azimuth !== e.azimuth) begin
               $error("azimuth: expected %0d actual %0d", e.azimuth, rsp_azimuth);
               failures++;
            end
            if (rsp_sweep_done !== e.sweep_done) begin
               $error("sweep_done: expected %0d actual %0d", e.sweep_done, rsp_sweep_done);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("scan_azimuth_segmenter_unit verification failed");
         $finish;
      end
   end

   initial begin
      point_row_type p;
      sas_pkg::sas_result_type got;
      reset_sweep_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: origin before any sweep, axes, extremes, wrap and stop.
      p = row(0, 0, 0); p.fixed = 1;
      p.res.keep = 0; p.res.segment_closed_before = 1; p.res.segment_number = 9'd2;
      p.res.azimuth = 18'd65536; p.res.sweep_done = 1;
      add_row(p);
      add_row(row(100, 0, 1));
      add_row(row(0, -100, 0));
      add_row(row(-100, 0, 0));
      add_row(row(0, 100, 0));
      add_row(row(100, 1, 0));
      add_row(row(100, -1, 0));
      add_row(row(8388607, 8388607, 1));
      add_row(row(-8388608, -8388608, 0));
      add_row(row(-8388608, 8388607, 0));
      add_row(row(8388607, -8388608, 0));
      add_row(row(0, 0, 0));
      add_row(row(-1, -1, 1));
      add_row(row(-1, 0, 0));
      add_row(row(-1, 1, 0));
      add_row(row(0, 0, 1));
      add_row(row(5, 3, 0));
      foreach (directed_rows[i]) begin
         p = directed_rows[i];
         send_point(p.x, p.y, p.first);
         if (p.fixed) begin
            got = expected_results[$];
            if (got !== p.res) begin
               $error("directed row %0d: expected %h predicted %h", i, p.res, got);
               failures++;
            end
         end
      end

      // Pressure: the receiver holds off while points keep coming.
      long_hold = 1;
      send_sweep(30);

      // Random sweeps across pose count settings, extremes included.
      write_pose_count(8'd1);   send_sweep(120);
      write_pose_count(8'd255); send_sweep(300);
      write_pose_count(8'd0);   send_sweep(60);
      write_pose_count(8'd7);   send_sweep(200);
      write_pose_count(8'd128); send_sweep(200);
      quiet_tail = 1;
      write_pose_count(8'd20);  send_sweep(120);

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("scan_azimuth_segmenter_unit verification clean");
      else
         $display("scan_azimuth_segmenter_unit verification failed");
      $finish;
   end
endmodule
